// ===== sv/triangle_circumcentre_top_defines.svh =====
// Assertion macros shared by the circumcentre block.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef TRIANGLE_CIRCUMCENTRE_TOP_DEFINES_SVH
`define TRIANGLE_CIRCUMCENTRE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tcc_pkg.sv =====
// Types and constants of the circumcentre block.
// No dependencies.
package tcc_pkg;
	localparam int BOX_WIDTH = 24;
	localparam int OUT_WIDTH = 24;
	localparam int QW        = OUT_WIDTH;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK         = 2'd0;
	localparam status_t ST_DEGENERATE = 2'd1;
	localparam status_t ST_OUTSIDE    = 2'd2;

	typedef logic [1:0] reg_index_t;
	localparam reg_index_t REG_MIN_X = 2'd0;
	localparam reg_index_t REG_MAX_X = 2'd1;
	localparam reg_index_t REG_MIN_Y = 2'd2;
	localparam reg_index_t REG_MAX_Y = 2'd3;

	typedef struct packed {
		logic degen;
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
	} tcc_flags_t;
endpackage

// ===== sv/tcc_if.sv =====
// Handshake interfaces for vertex words and result words.
// Depends on tcc_pkg.
interface tcc_vtx_if #(parameter int COORD_WIDTH = 24);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] first_x;
	logic signed [COORD_WIDTH-1:0] first_y;
	logic signed [COORD_WIDTH-1:0] second_x;
	logic signed [COORD_WIDTH-1:0] second_y;
	logic signed [COORD_WIDTH-1:0] third_x;
	logic signed [COORD_WIDTH-1:0] third_y;

	modport source(output valid, first_x, first_y, second_x, second_y, third_x, third_y,
		input ready);
	modport sink(input valid, first_x, first_y, second_x, second_y, third_x, third_y,
		output ready);
endinterface

interface tcc_res_if;
	logic valid;
	logic ready;
	logic signed [tcc_pkg::OUT_WIDTH-1:0] centre_x;
	logic signed [tcc_pkg::OUT_WIDTH-1:0] centre_y;
	tcc_pkg::status_t status;

	modport source(output valid, centre_x, centre_y, status, input ready);
	modport sink(input valid, centre_x, centre_y, status, output ready);
endinterface

// ===== sv/tcc_front.sv =====
// Front pipeline: differences, squares and products up to the two numerators
// and the shared denominator. Four register stages. Depends on tcc_pkg.
module tcc_front #(
	parameter int COORD_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [COORD_WIDTH-1:0] x1,
	input  logic signed [COORD_WIDTH-1:0] y1,
	input  logic signed [COORD_WIDTH-1:0] x2,
	input  logic signed [COORD_WIDTH-1:0] y2,
	input  logic signed [COORD_WIDTH-1:0] x3,
	input  logic signed [COORD_WIDTH-1:0] y3,
	output logic out_valid,
	output logic signed [3*COORD_WIDTH+3:0] num_x,
	output logic signed [3*COORD_WIDTH+3:0] num_y,
	output logic signed [2*COORD_WIDTH+3:0] den
);
	import tcc_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int DW   = W + 1;
	localparam int SQW  = 2 * W;
	localparam int SW   = 2 * W + 2;
	localparam int PW   = 2 * DW;
	localparam int PPW  = 2 * W + 3;
	localparam int DENW = 2 * W + 4;
	localparam int NW   = 3 * W + 4;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [DW-1:0] dx2_s1, dy2_s1, dx3_s1, dy3_s1;
	logic signed [SQW-1:0] x1q_s1, y1q_s1, x2q_s1, y2q_s1, x3q_s1, y3q_s1;
	logic signed [DW-1:0] dx2_s2, dy2_s2, dx3_s2, dy3_s2;
	logic signed [SW-1:0] s2_s2, s3_s2;
	logic signed [PW-1:0] pa_s2, pb_s2;
	logic signed [DENW-1:0] den_s3, den_s4;
	logic signed [PPW-1:0] alo_s3, ahi_s3, blo_s3, bhi_s3;
	logic signed [PPW-1:0] clo_s3, chi_s3, dlo_s3, dhi_s3;
	logic signed [NW-1:0] nx_s4, ny_s4;

	logic signed [W:0] s2_lo, s3_lo;
	logic signed [W+1:0] s2_hi, s3_hi;

	assign s2_lo = signed'({1'b0, s2_s2[W-1:0]});
	assign s3_lo = signed'({1'b0, s3_s2[W-1:0]});
	assign s2_hi = s2_s2[SW-1:W];
	assign s3_hi = s3_s2[SW-1:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx2_s1 <= DW'(x2) - DW'(x1);
			dy2_s1 <= DW'(y2) - DW'(y1);
			dx3_s1 <= DW'(x3) - DW'(x1);
			dy3_s1 <= DW'(y3) - DW'(y1);
			x1q_s1 <= x1 * x1;
			y1q_s1 <= y1 * y1;
			x2q_s1 <= x2 * x2;
			y2q_s1 <= y2 * y2;
			x3q_s1 <= x3 * x3;
			y3q_s1 <= y3 * y3;

			dx2_s2 <= dx2_s1;
			dy2_s2 <= dy2_s1;
			dx3_s2 <= dx3_s1;
			dy3_s2 <= dy3_s1;
			s2_s2 <= SW'(x2q_s1) + SW'(y2q_s1) - SW'(x1q_s1) - SW'(y1q_s1);
			s3_s2 <= SW'(x3q_s1) + SW'(y3q_s1) - SW'(x1q_s1) - SW'(y1q_s1);
			pa_s2 <= dx3_s1 * dy2_s1;
			pb_s2 <= dx2_s1 * dy3_s1;

			den_s3 <= (DENW'(pa_s2) - DENW'(pb_s2)) <<< 1;
			alo_s3 <= dy2_s2 * s3_lo;
			ahi_s3 <= dy2_s2 * s3_hi;
			blo_s3 <= dy3_s2 * s2_lo;
			bhi_s3 <= dy3_s2 * s2_hi;
			clo_s3 <= dx3_s2 * s2_lo;
			chi_s3 <= dx3_s2 * s2_hi;
			dlo_s3 <= dx2_s2 * s3_lo;
			dhi_s3 <= dx2_s2 * s3_hi;

			den_s4 <= den_s3;
			nx_s4 <= (NW'(ahi_s3) <<< W) + NW'(alo_s3) - (NW'(bhi_s3) <<< W) - NW'(blo_s3);
			// The y numerator is negated so that both share the same denominator.
			ny_s4 <= (NW'(chi_s3) <<< W) + NW'(clo_s3) - (NW'(dhi_s3) <<< W) - NW'(dlo_s3);
		end
	end

	assign out_valid = v_s4;
	assign num_x = nx_s4;
	assign num_y = ny_s4;
	assign den = den_s4;
endmodule

// ===== sv/tcc_div.sv =====
// Pipelined restoring divider for both coordinates, one quotient bit a stage,
// with sign, overflow and degenerate detection in front. Depends on tcc_pkg.
module tcc_div #(
	parameter int COORD_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [3*COORD_WIDTH+3:0] num_x,
	input  logic signed [3*COORD_WIDTH+3:0] num_y,
	input  logic signed [2*COORD_WIDTH+3:0] den,
	output logic out_valid,
	output logic [tcc_pkg::QW-1:0] quo_x,
	output logic [tcc_pkg::QW-1:0] quo_y,
	output tcc_pkg::tcc_flags_t flags
);
	import tcc_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int DENW = 2 * W + 4;
	localparam int NW   = 3 * W + 4;
	localparam int AW   = DENW + QW;
	localparam int CW   = (NW > AW) ? NW : AW;

	logic v_s1, v_s2;
	logic [NW-1:0] ax_s1, ay_s1;
	logic [DENW-1:0] ad_s1;
	tcc_flags_t fl_s1;

	logic v_s [0:QW];
	logic [AW-1:0] accx_s [0:QW];
	logic [AW-1:0] accy_s [0:QW];
	logic [QW-1:0] qx_s [0:QW];
	logic [QW-1:0] qy_s [0:QW];
	logic [DENW-1:0] ad_s [0:QW];
	tcc_flags_t fl_s [0:QW];

	assign v_s2 = v_s[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k <= QW; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= in_valid;
			v_s[0] <= v_s1;
			for (int k = 0; k < QW; k++) begin
				v_s[k+1] <= v_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [AW-1:0] tx, ty;
		if (en) begin
			ax_s1 <= num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
			ay_s1 <= num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
			ad_s1 <= den[DENW-1] ? DENW'(-den) : DENW'(den);
			fl_s1.degen <= (den == '0);
			fl_s1.neg_x <= num_x[NW-1] ^ den[DENW-1];
			fl_s1.neg_y <= num_y[NW-1] ^ den[DENW-1];
			fl_s1.ovf_x <= 1'b0;
			fl_s1.ovf_y <= 1'b0;

			// A quotient that needs more than QW bits lies outside any box.
			accx_s[0] <= AW'(ax_s1);
			accy_s[0] <= AW'(ay_s1);
			qx_s[0] <= '0;
			qy_s[0] <= '0;
			ad_s[0] <= ad_s1;
			fl_s[0].degen <= fl_s1.degen;
			fl_s[0].neg_x <= fl_s1.neg_x;
			fl_s[0].neg_y <= fl_s1.neg_y;
			fl_s[0].ovf_x <= CW'(ax_s1) >= (CW'(ad_s1) << QW);
			fl_s[0].ovf_y <= CW'(ay_s1) >= (CW'(ad_s1) << QW);

			for (int k = 0; k < QW; k++) begin
				tx = AW'(ad_s[k]) << (QW - 1 - k);
				ty = AW'(ad_s[k]) << (QW - 1 - k);
				if (accx_s[k] >= tx) begin
					accx_s[k+1] <= accx_s[k] - tx;
					qx_s[k+1] <= qx_s[k] | (QW'(1) << (QW - 1 - k));
				end else begin
					accx_s[k+1] <= accx_s[k];
					qx_s[k+1] <= qx_s[k];
				end
				if (accy_s[k] >= ty) begin
					accy_s[k+1] <= accy_s[k] - ty;
					qy_s[k+1] <= qy_s[k] | (QW'(1) << (QW - 1 - k));
				end else begin
					accy_s[k+1] <= accy_s[k];
					qy_s[k+1] <= qy_s[k];
				end
				ad_s[k+1] <= ad_s[k];
				fl_s[k+1] <= fl_s[k];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo_x = qx_s[QW];
	assign quo_y = qy_s[QW];
	assign flags = fl_s[QW];

	`include "triangle_circumcentre_top_defines.svh"

	`TCC_ASSERT_NOW(a_div_valid_follows, en && v_s1, 1'b1, "divider valid lost")
	`TCC_ASSERT_NEXT(a_div_enter, en && in_valid, v_s1, "divider did not take a word")
	`TCC_ASSERT_NEXT(a_div_chain, en && v_s2, v_s[1], "divider chain dropped a word")
endmodule

// ===== sv/triangle_circumcentre_top.sv =====
// Circumcentre of an integer triangle with box check; top level.
// Depends on tcc_pkg, tcc_if, tcc_front and tcc_div.
// The block takes one triangle per clock cycle unless the result side stalls. In
// order, four stages form the numerators and the denominator, two take signs and
// detect quotients too large for the output, 24 stages of the shared divider
// produce one quotient bit each, and a last stage checks the box and holds the
// result word. When the result side stalls, the whole pipeline holds.
module triangle_circumcentre_top #(
	parameter int COORD_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,
	tcc_vtx_if.sink vtx,
	tcc_res_if.source res,
	input  logic cfg_we,
	input  tcc_pkg::reg_index_t cfg_index,
	input  logic [tcc_pkg::BOX_WIDTH-1:0] cfg_data
);
	import tcc_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int DENW = 2 * W + 4;
	localparam int NW   = 3 * W + 4;
	localparam int CXW  = OUT_WIDTH + 1;

	logic en;
	logic f_valid, d_valid;
	logic signed [NW-1:0] num_x, num_y;
	logic signed [DENW-1:0] den;
	logic [QW-1:0] quo_x, quo_y;
	tcc_flags_t flags;
	logic signed [BOX_WIDTH-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic signed [CXW-1:0] cx, cy;
	logic outside;
	logic v_s1;
	logic signed [OUT_WIDTH-1:0] cx_s1, cy_s1;
	status_t st_s1;

	assign en = !v_s1 || res.ready;
	assign vtx.ready = en;

	tcc_front #(.COORD_WIDTH(W)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vtx.valid),
		.x1(W'(vtx.first_x)), .y1(W'(vtx.first_y)),
		.x2(W'(vtx.second_x)), .y2(W'(vtx.second_y)),
		.x3(W'(vtx.third_x)), .y3(W'(vtx.third_y)),
		.out_valid(f_valid), .num_x(num_x), .num_y(num_y), .den(den)
	);

	tcc_div #(.COORD_WIDTH(W)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(f_valid),
		.num_x(num_x), .num_y(num_y), .den(den),
		.out_valid(d_valid), .quo_x(quo_x), .quo_y(quo_y), .flags(flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= {1'b1, {(BOX_WIDTH-1){1'b0}}};
			max_x_q <= {1'b0, {(BOX_WIDTH-1){1'b1}}};
			min_y_q <= {1'b1, {(BOX_WIDTH-1){1'b0}}};
			max_y_q <= {1'b0, {(BOX_WIDTH-1){1'b1}}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_X: min_x_q <= cfg_data;
				REG_MAX_X: max_x_q <= cfg_data;
				REG_MIN_Y: min_y_q <= cfg_data;
				REG_MAX_Y: max_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cx = flags.neg_x ? -signed'({1'b0, quo_x}) : signed'({1'b0, quo_x});
	assign cy = flags.neg_y ? -signed'({1'b0, quo_y}) : signed'({1'b0, quo_y});
	assign outside = flags.ovf_x || flags.ovf_y
		|| (cx < CXW'(min_x_q)) || (cx > CXW'(max_x_q))
		|| (cy < CXW'(min_y_q)) || (cy > CXW'(max_y_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (flags.degen) begin
				st_s1 <= ST_DEGENERATE;
				cx_s1 <= '0;
				cy_s1 <= '0;
			end else if (outside) begin
				st_s1 <= ST_OUTSIDE;
				cx_s1 <= '0;
				cy_s1 <= '0;
			end else begin
				st_s1 <= ST_OK;
				cx_s1 <= cx[OUT_WIDTH-1:0];
				cy_s1 <= cy[OUT_WIDTH-1:0];
			end
		end
	end

	assign res.valid = v_s1;
	assign res.centre_x = cx_s1;
	assign res.centre_y = cy_s1;
	assign res.status = st_s1;

	`include "triangle_circumcentre_top_defines.svh"

	`TCC_ASSERT_NOW(a_zero_unless_ok, res.valid && res.status != ST_OK,
		res.centre_x == '0 && res.centre_y == '0, "centre not zero on bad status")
	`TCC_ASSERT_NOW(a_status_code, res.valid,
		res.status == ST_OK || res.status == ST_DEGENERATE || res.status == ST_OUTSIDE,
		"status code out of range")
	`TCC_ASSERT_NOW(a_ready_only_stalls, !vtx.ready, res.valid && !res.ready,
		"input stalled without a waiting result")
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for triangle_circumcentre_top: random and directed triangles
// are checked against an exact 128-bit circumcentre calculation, under several boxes.
// Depends on tcc_pkg, tcc_if and the block's RTL.
`timescale 1ns / 1ps

module testbench;
	import tcc_pkg::*;

	localparam int CW = 24;
	localparam int SETTLE = 40;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [127:0] exact_t;
	typedef logic signed [BOX_WIDTH-1:0] box_t;

	typedef struct {
		coord_t x1, y1, x2, y2, x3, y3;
	} triangle_t;

	typedef struct {
		logic signed [OUT_WIDTH-1:0] cx;
		logic signed [OUT_WIDTH-1:0] cy;
		status_t status;
	} centre_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	reg_index_t cfg_index;
	logic [BOX_WIDTH-1:0] cfg_data;

	tcc_vtx_if #(.COORD_WIDTH(CW)) vtx ();
	tcc_res_if res ();

	triangle_circumcentre_top #(.COORD_WIDTH(CW)) u_dut (
		.clk(clk), .arst_n(arst_n), .vtx(vtx.sink), .res(res.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	triangle_t pending_tri[$];
	centre_t expected_centres[$];
	box_t box_lo_x, box_hi_x, box_lo_y, box_hi_y;
	int mismatches;
	logic noisy;
	logic long_stall;

	function automatic centre_t circumcentre(triangle_t t);
		exact_t x1, y1, x2, y2, x3, y3, dx2, dy2, dx3, dy3, base, s2, s3, den, qx, qy;
		centre_t r;
		x1 = t.x1; y1 = t.y1; x2 = t.x2; y2 = t.y2; x3 = t.x3; y3 = t.y3;
		dx2 = x2 - x1; dy2 = y2 - y1; dx3 = x3 - x1; dy3 = y3 - y1;
		base = x1 * x1 + y1 * y1;
		s2 = x2 * x2 + y2 * y2 - base;
		s3 = x3 * x3 + y3 * y3 - base;
		den = 2 * (dx3 * dy2 - dx2 * dy3);
		r.cx = '0;
		r.cy = '0;
		if (den == 0) begin
			r.status = ST_DEGENERATE;
			return r;
		end
		qx = (dy2 * s3 - dy3 * s2) / den;
		qy = (dx2 * s3 - dx3 * s2) / (-den);
		if (qx < exact_t'(box_lo_x) || qx > exact_t'(box_hi_x) ||
				qy < exact_t'(box_lo_y) || qy > exact_t'(box_hi_y)) begin
			r.status = ST_OUTSIDE;
			return r;
		end
		r.cx = qx[OUT_WIDTH-1:0];
		r.cy = qy[OUT_WIDTH-1:0];
		r.status = ST_OK;
		return r;
	endfunction

	function automatic coord_t rand_coord(int span);
		if (span == 0)
			return coord_t'($urandom);
		return coord_t'($signed($urandom_range(2 * span)) - span);
	endfunction

	function automatic triangle_t rand_triangle(int span);
		triangle_t t;
		int k;
		int sel;
		sel = $urandom_range(99);
		t.x1 = rand_coord(span); t.y1 = rand_coord(span);
		t.x2 = rand_coord(span); t.y2 = rand_coord(span);
		t.x3 = rand_coord(span); t.y3 = rand_coord(span);
		if (sel < 15) begin
			t.x1 = rand_coord(0); t.y1 = rand_coord(0);
			t.x2 = rand_coord(0); t.y2 = rand_coord(0);
			t.x3 = rand_coord(0); t.y3 = rand_coord(0);
		end else if (sel < 25) begin
			k = $signed($urandom_range(6)) - 3;
			t.x1 = rand_coord(1000); t.y1 = rand_coord(1000);
			t.x2 = t.x1 + rand_coord(300); t.y2 = t.y1 + rand_coord(300);
			t.x3 = coord_t'(t.x1 + k * (t.x2 - t.x1));
			t.y3 = coord_t'(t.y1 + k * (t.y2 - t.y1));
		end else if (sel < 30) begin
			t.x2 = t.x1; t.y2 = t.y1;
		end
		return t;
	endfunction

	function automatic triangle_t make_tri(int a, int b, int c, int d, int e, int f);
		triangle_t t;
		t.x1 = coord_t'(a); t.y1 = coord_t'(b);
		t.x2 = coord_t'(c); t.y2 = coord_t'(d);
		t.x3 = coord_t'(e); t.y3 = coord_t'(f);
		return t;
	endfunction

	task automatic write_box(int lx, int hx, int ly, int hy);
		int vals[4];
		vals = '{lx, hx, ly, hy};
		for (int i = 0; i < 4; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= reg_index_t'(i);
			cfg_data <= vals[i][BOX_WIDTH-1:0];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		box_lo_x = box_t'(lx); box_hi_x = box_t'(hx);
		box_lo_y = box_t'(ly); box_hi_y = box_t'(hy);
	endtask

	task automatic drain;
		while (pending_tri.size() != 0 || expected_centres.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_random(int count, int span);
		for (int i = 0; i < count; i++)
			pending_tri.push_back(rand_triangle(span));
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx.valid <= 1'b0;
			vtx.first_x <= '0; vtx.first_y <= '0;
			vtx.second_x <= '0; vtx.second_y <= '0;
			vtx.third_x <= '0; vtx.third_y <= '0;
		end else begin
			if (vtx.valid && vtx.ready) begin
				expected_centres.push_back(circumcentre(pending_tri[0]));
				void'(pending_tri.pop_front());
			end
			if (vtx.valid && !vtx.ready) begin
				vtx.valid <= 1'b1;
			end else if (pending_tri.size() != 0 && !(noisy && $urandom_range(99) < 30)) begin
				vtx.valid <= 1'b1;
				vtx.first_x <= pending_tri[0].x1; vtx.first_y <= pending_tri[0].y1;
				vtx.second_x <= pending_tri[0].x2; vtx.second_y <= pending_tri[0].y2;
				vtx.third_x <= pending_tri[0].x3; vtx.third_y <= pending_tri[0].y3;
			end else begin
				vtx.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_centres.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: x=%0d y=%0d status=%0d",
							res.centre_x, res.centre_y, res.status);
				end else begin
					if (res.centre_x !== expected_centres[0].cx ||
							res.centre_y !== expected_centres[0].cy ||
							res.status !== expected_centres[0].status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
								expected_centres[0].cx, expected_centres[0].cy,
								expected_centres[0].status,
								res.centre_x, res.centre_y, res.status);
					end
					void'(expected_centres.pop_front());
				end
			end
			res.ready <= !long_stall && !(noisy && $urandom_range(99) < 30);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MIN_X;
		cfg_data = '0;
		noisy = 1'b1;
		long_stall = 1'b0;
		mismatches = 0;
		box_lo_x = -24'sd8388608; box_hi_x = 24'sd8388607;
		box_lo_y = -24'sd8388608; box_hi_y = 24'sd8388607;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_tri.push_back(make_tri(-8388608, -8388608, 8388607, -8388608, -8388608, 8388607));
		pending_tri.push_back(make_tri(8388607, 8388607, -8388608, 8388607, 8388607, -8388608));
		pending_tri.push_back(make_tri(-8388608, -8388608, 8388607, 8388607, 0, 1));
		pending_tri.push_back(make_tri(-8388608, 8388607, 8388607, 8388607, 8388607, -8388608));
		pending_tri.push_back(make_tri(5, 5, 5, 5, 5, 5));
		pending_tri.push_back(make_tri(0, 0, 1, 1, 2, 2));
		pending_tri.push_back(make_tri(-8388608, -8388608, 0, 0, 8388607, 8388607));
		pending_tri.push_back(make_tri(0, 0, 2, 0, 0, 2));
		pending_tri.push_back(make_tri(0, 0, 3, 0, 0, 3));
		pending_tri.push_back(make_tri(0, 0, -3, 0, 0, -3));
		pending_tri.push_back(make_tri(0, 0, 1, 0, 0, 1));
		pending_tri.push_back(make_tri(0, 0, 1, 0, 8388607, 1));
		pending_tri.push_back(make_tri(0, 0, -1, 0, -8388608, 1));
		pending_tri.push_back(make_tri(-1, -1, -1, -1, 3, 4));
		drain();

		write_box(-100, 100, -100, 100);
		pending_tri.push_back(make_tri(-100, -100, 100, -100, -100, 100));
		pending_tri.push_back(make_tri(-202, 0, 0, 0, 0, 200));
		pending_tri.push_back(make_tri(0, -202, 0, 0, 200, 0));
		pending_tri.push_back(make_tri(-101, -101, 99, -101, -101, 99));
		queue_random(400, 250);
		fork
			begin
				repeat (60) @(posedge clk);
				long_stall <= 1'b1;
				repeat (400) @(posedge clk);
				long_stall <= 1'b0;
			end
		join_none
		drain();

		noisy = 1'b0;
		write_box(8388607, -8388608, -8388608, 8388607);
		queue_random(200, 3000);
		drain();

		noisy = 1'b1;
		write_box(0, 0, -8388608, 8388607);
		pending_tri.push_back(make_tri(-1, 0, 1, 0, 0, 7));
		queue_random(300, 50);
		drain();

		write_box(-8388608, 8388607, 0, 8388607);
		queue_random(400, 100000);
		drain();

		write_box(-8388608, 8388607, -8388608, 8388607);
		queue_random(400, 0);
		drain();

		if (mismatches == 0 && expected_centres.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
